@@ sv/csba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csba_pkg
// Shared types and codes of the contiguous slot bitmap allocator.
// ----------------------------------------------------------------------------
package csba_pkg;

    localparam int CNT_W  = 5;   // request count field
    localparam int SLOT_W = 4;   // slot fields
    localparam int STAT_W = 2;   // status field
    localparam int LEN_W  = 7;   // slot bounds and sums, holds values up to 127

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOROOM  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTUSED = 2'd2;
    localparam logic [STAT_W-1:0] ST_PASTEND = 2'd3;

    typedef enum logic
    {
        S_IDLE,
        S_SCAN
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed
    {
        logic             start;   // launch the scan token into the first cell
        logic             kill;    // drop the token, scan is over
        logic             wr_en;   // write the range lo .. hi-1
        logic             wr_val;  // 1 marks used, 0 frees
        logic [CNT_W-1:0] cnt;     // run length wanted by the scan
        logic [LEN_W-1:0] lo;
        logic [LEN_W-1:0] hi;
    } ctl_t;

endpackage

@@ sv/contiguous_slot_bitmap_allocator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_slot_bitmap_allocator_top
// First-fit allocator of contiguous slots over a used bitmap.
// ----------------------------------------------------------------------------
// One request at a time. A free request, and an allocate of zero slots, is
// handled in the cycle it is accepted and its result is registered for the
// next cycle. An allocate passes a scan token down the row of slot cells, one
// cell per cycle, each cell extending the run of free slots from its
// neighbour; its result is registered once the cell at the end of the first
// fitting run claims it, or once the token reaches the last cell if none fits.
// The next request is taken only once the scan has finished and the result
// register is empty or being read in the same cycle.
module contiguous_slot_bitmap_allocator_top #(
    parameter int NUM_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // count[4:0], start_slot[8:5], zero pad
    input  logic        s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // status[1:0], slot[5:2], zero pad
);

    localparam int CW = csba_pkg::CNT_W;
    localparam int SW = csba_pkg::SLOT_W;

    csba_pkg::ctl_t                ctl;
    logic [NUM_SLOTS-1:0]          tok_q;
    logic [NUM_SLOTS-1:0]          tok_in;
    logic [NUM_SLOTS-1:0][CW-1:0]  run_q;
    logic [NUM_SLOTS-1:0][CW-1:0]  run_in;
    logic [NUM_SLOTS-1:0]          hit_v;
    logic [NUM_SLOTS-1:0]          hole_v;
    logic [csba_pkg::STAT_W-1:0]   rsp_status;
    logic [SW-1:0]                 rsp_slot;

    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign tok_in[i] = ctl.start;
            assign run_in[i] = '0;
        end
        else
        begin : g_link
            assign tok_in[i] = tok_q[i-1];
            assign run_in[i] = run_q[i-1];
        end

        csba_cell #(
            .IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .tok_in  (tok_in[i]),
            .run_in  (run_in[i]),
            .tok_out (tok_q[i]),
            .run_out (run_q[i]),
            .hit     (hit_v[i]),
            .hole    (hole_v[i])
        );
    end

    csba_ctrl #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_axis_tvalid),
        .req_ready  (s_axis_tready),
        .req_op     (s_axis_tuser),
        .req_cnt    (s_axis_tdata[CW-1:0]),
        .req_start  (s_axis_tdata[CW+SW-1:CW]),
        .rsp_valid  (m_axis_tvalid),
        .rsp_ready  (m_axis_tready),
        .rsp_status (rsp_status),
        .rsp_slot   (rsp_slot),
        .ctl        (ctl),
        .hit_any    (|hit_v),
        .hole_any   (|hole_v)
    );

    assign m_axis_tdata = {2'b00, rsp_slot, rsp_status};

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_q))
        else $error("more than one scan token in the row");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_v))
        else $error("several cells claim the run end");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.wr_en && ctl.wr_val) |-> ($countones(hit_v) == 1))
        else $error("slots marked used without a matching run");

endmodule

@@ sv/csba_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csba_cell
// One slot of the bitmap: used bit, scan token and run length of free slots.
// ----------------------------------------------------------------------------
module csba_cell #(
    parameter int IDX = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  csba_pkg::ctl_t             ctl,
    input  logic                       tok_in,
    input  logic [csba_pkg::CNT_W-1:0] run_in,
    output logic                       tok_out,
    output logic [csba_pkg::CNT_W-1:0] run_out,
    output logic                       hit,
    output logic                       hole
);

    localparam logic [csba_pkg::LEN_W-1:0] MY_IDX = csba_pkg::LEN_W'(IDX);
    localparam logic [csba_pkg::CNT_W-1:0] RUN_MAX = '1;

    logic                       used_reg;
    logic                       used_next;
    logic                       tok_reg;
    logic                       tok_next;
    logic [csba_pkg::CNT_W-1:0] run_reg;
    logic [csba_pkg::CNT_W-1:0] run_next;
    logic [csba_pkg::CNT_W-1:0] run_now;
    logic                       in_rng;

    assign in_rng = (MY_IDX >= ctl.lo) && (MY_IDX < ctl.hi);

    // run saturates, counts never exceed the field's range anyway
    always_comb
    begin
        if (used_reg)
        begin
            run_now = '0;
        end
        else if (run_in == RUN_MAX)
        begin
            run_now = run_in;
        end
        else
        begin
            run_now = run_in + 1'b1;
        end
    end

    assign hit       = tok_reg && !used_reg && (run_now >= ctl.cnt);
    assign hole      = in_rng && !used_reg;
    assign used_next = (ctl.wr_en && in_rng) ? ctl.wr_val : used_reg;
    assign tok_next  = ctl.kill ? 1'b0 : tok_in;
    assign run_next  = tok_reg ? run_now : run_reg;
    assign tok_out   = tok_reg;
    assign run_out   = run_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            tok_reg  <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg <= run_next;
    end

endmodule

@@ sv/csba_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csba_ctrl
// Request sequencer: drives the cell row, tracks the scan, holds the result.
// ----------------------------------------------------------------------------
module csba_ctrl #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic                        req_op,
    input  logic [csba_pkg::CNT_W-1:0]  req_cnt,
    input  logic [csba_pkg::SLOT_W-1:0] req_start,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [csba_pkg::STAT_W-1:0] rsp_status,
    output logic [csba_pkg::SLOT_W-1:0] rsp_slot,
    output csba_pkg::ctl_t              ctl,
    input  logic                        hit_any,
    input  logic                        hole_any
);

    localparam int PW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [PW-1:0] POS_LAST = PW'(NUM_SLOTS - 1);
    localparam logic [csba_pkg::LEN_W-1:0] SLOTS_L = csba_pkg::LEN_W'(NUM_SLOTS);

    csba_pkg::state_t            state_reg;
    csba_pkg::state_t            state_next;
    logic [PW-1:0]               pos_reg;
    logic [PW-1:0]               pos_next;
    logic [csba_pkg::CNT_W-1:0]  cnt_reg;
    logic [csba_pkg::CNT_W-1:0]  cnt_next;
    logic                        rsp_valid_reg;
    logic                        rsp_valid_next;
    logic [csba_pkg::STAT_W-1:0] rsp_status_reg;
    logic [csba_pkg::STAT_W-1:0] rsp_status_next;
    logic [csba_pkg::SLOT_W-1:0] rsp_slot_reg;
    logic [csba_pkg::SLOT_W-1:0] rsp_slot_next;

    logic                        acc;
    logic                        pos_last;
    logic                        scan_end;
    logic                        cnt_zero;
    logic                        past_end;
    logic [csba_pkg::LEN_W-1:0]  free_hi;
    logic [csba_pkg::LEN_W-1:0]  run_hi;
    logic [csba_pkg::LEN_W-1:0]  run_lo;

    assign acc      = req_valid && req_ready;
    assign pos_last = (pos_reg == POS_LAST);
    assign scan_end = (state_reg == csba_pkg::S_SCAN) && (hit_any || pos_last);
    assign cnt_zero = (req_cnt == '0);
    assign free_hi  = csba_pkg::LEN_W'(req_start) + csba_pkg::LEN_W'(req_cnt);
    assign past_end = (free_hi > SLOTS_L);
    assign run_hi   = csba_pkg::LEN_W'(pos_reg) + 1'b1;
    assign run_lo   = run_hi - csba_pkg::LEN_W'(cnt_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            csba_pkg::S_IDLE:
            begin
                if (acc && (req_op == csba_pkg::OP_ALLOC) && !cnt_zero)
                begin
                    state_next = csba_pkg::S_SCAN;
                end
            end
            csba_pkg::S_SCAN:
            begin
                if (hit_any || pos_last)
                begin
                    state_next = csba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = csba_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        req_ready       = 1'b0;
        ctl             = '0;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_status_next = rsp_status_reg;
        rsp_slot_next   = rsp_slot_reg;
        case (state_reg)
            csba_pkg::S_IDLE:
            begin
                // result register must be empty or draining at this edge
                req_ready = !rsp_valid_reg || rsp_ready;
                ctl.lo    = csba_pkg::LEN_W'(req_start);
                ctl.hi    = free_hi;
                ctl.cnt   = req_cnt;
                pos_next  = '0;
                cnt_next  = req_cnt;
                if (acc)
                begin
                    if (req_op == csba_pkg::OP_FREE)
                    begin
                        ctl.wr_en       = !past_end;
                        ctl.wr_val      = 1'b0;
                        rsp_valid_next  = 1'b1;
                        rsp_slot_next   = '0;
                        if (past_end)
                        begin
                            rsp_status_next = csba_pkg::ST_PASTEND;
                        end
                        else if (hole_any)
                        begin
                            rsp_status_next = csba_pkg::ST_NOTUSED;
                        end
                        else
                        begin
                            rsp_status_next = csba_pkg::ST_OK;
                        end
                    end
                    else if (cnt_zero)
                    begin
                        rsp_valid_next  = 1'b1;
                        rsp_status_next = csba_pkg::ST_OK;
                        rsp_slot_next   = '0;
                    end
                    else
                    begin
                        ctl.start = 1'b1;
                    end
                end
            end
            csba_pkg::S_SCAN:
            begin
                ctl.cnt    = cnt_reg;
                ctl.lo     = run_lo;
                ctl.hi     = run_hi;
                ctl.wr_en  = hit_any;
                ctl.wr_val = 1'b1;
                ctl.kill   = hit_any || pos_last;
                pos_next   = pos_reg + 1'b1;
                if (hit_any)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = csba_pkg::ST_OK;
                    rsp_slot_next   = run_lo[csba_pkg::SLOT_W-1:0];
                end
                else if (pos_last)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = csba_pkg::ST_NOROOM;
                    rsp_slot_next   = '0;
                end
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csba_pkg::S_IDLE;
            pos_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        rsp_status_reg <= rsp_status_next;
        rsp_slot_reg   <= rsp_slot_next;
    end

    assign rsp_valid  = rsp_valid_reg;
    assign rsp_status = rsp_status_reg;
    assign rsp_slot   = rsp_slot_reg;

    a_hit_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        hit_any |-> (state_reg == csba_pkg::S_SCAN))
        else $error("hit reported outside a scan");

    a_scan_result: assert property (@(posedge clk) disable iff (!rst_n)
        scan_end |=> rsp_valid_reg)
        else $error("finished scan left no result");

    a_empty_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == csba_pkg::S_SCAN) |-> !rsp_valid_reg)
        else $error("result register busy while scanning");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the contiguous slot bitmap allocator.
// ----------------------------------------------------------------------------
// A directed table covers the field extremes, zero counts, oversize allocates,
// frees past the end and double frees. Random traffic follows: mostly
// allocates and frees of runs still held, with some overlapping frees and
// raw noise. A shadow bitmap predicts every reply not typed into the table.
// Both stream sides idle at random while the run is going.
module testbench;

    localparam int NUM_SLOTS    = 16;
    localparam int RANDOM_ITEMS = 930;
    localparam int IDLE_LIMIT   = 2000;
    localparam int MAX_SHOWN    = 10;

    typedef struct packed
    {
        logic [csba_pkg::STAT_W-1:0] status;
        logic [csba_pkg::SLOT_W-1:0] slot;
    } slot_reply_t;

    typedef struct packed
    {
        logic                        op;
        logic [csba_pkg::CNT_W-1:0]  cnt;
        logic [csba_pkg::SLOT_W-1:0] start;
        logic                        fixed;   // reply typed in below, not predicted
        logic [csba_pkg::STAT_W-1:0] status;
        logic [csba_pkg::SLOT_W-1:0] slot;
    } request_row_t;

    typedef struct packed
    {
        logic [csba_pkg::SLOT_W-1:0] first;
        logic [csba_pkg::CNT_W-1:0]  len;
    } held_run_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // count[4:0], start_slot[8:5], zero pad
    logic        s_axis_tuser;    // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;    // status[1:0], slot[5:2], zero pad

    logic [NUM_SLOTS-1:0] shadow_used;
    slot_reply_t          awaited_replies[$];
    held_run_t            held_runs[$];
    int                   errors = 0;
    int                   idle_cycles = 0;
    int                   burst_left = 0;
    int                   sent_count = 0;
    int                   status_tally[4] = '{0, 0, 0, 0};

    request_row_t directed_rows[24] = '{
        '{csba_pkg::OP_ALLOC, 5'd0,  4'd0,  1'b1, csba_pkg::ST_OK, 4'd0}, // zero count allocate
        '{csba_pkg::OP_ALLOC, 5'd1,  4'd0,  1'b1, csba_pkg::ST_OK, 4'd0},
        '{csba_pkg::OP_ALLOC, 5'd31, 4'd15, 1'b1, csba_pkg::ST_NOROOM, 4'd0}, // far too big
        '{csba_pkg::OP_ALLOC, 5'd17, 4'd0,  1'b1, csba_pkg::ST_NOROOM, 4'd0},
        '{csba_pkg::OP_ALLOC, 5'd16, 4'd0,  1'b0, csba_pkg::ST_OK, 4'd0},
        '{csba_pkg::OP_ALLOC, 5'd3,  4'd0,  1'b0, csba_pkg::ST_OK, 4'd0},
        '{csba_pkg::OP_FREE,  5'd2,  4'd15, 1'b1, csba_pkg::ST_PASTEND, 4'd0},
        '{csba_pkg::OP_FREE,  5'd31, 4'd0,  1'b1, csba_pkg::ST_PASTEND, 4'd0},
        '{csba_pkg::OP_FREE,  5'd0,  4'd2,  1'b1, csba_pkg::ST_OK, 4'd0}, // zero count free
        '{csba_pkg::OP_FREE,  5'd1,  4'd1,  1'b0, csba_pkg::ST_OK, 4'd0},
        '{csba_pkg::OP_ALLOC, 5'd1,  4'd0,  1'b0, csba_pkg::ST_OK, 4'd0}, // refills the hole
        '{csba_pkg::OP_FREE,  5'd8,  4'd0,  1'b0, csba_pkg::ST_OK, 4'd0}, // frees a range partly not in use
        '{csba_pkg::OP_FREE,  5'd16, 4'd0,  1'b0, csba_pkg::ST_OK, 4'd0},
        '{csba_pkg::OP_ALLOC, 5'd16, 4'd0,  1'b0, csba_pkg::ST_OK, 4'd0},
        '{csba_pkg::OP_FREE,  5'd1,  4'd15, 1'b0, csba_pkg::ST_OK, 4'd0},
        '{csba_pkg::OP_ALLOC, 5'd1,  4'd0,  1'b0, csba_pkg::ST_OK, 4'd0}, // lands on last slot
        '{csba_pkg::OP_FREE,  5'd16, 4'd0,  1'b0, csba_pkg::ST_OK, 4'd0},
        '{csba_pkg::OP_ALLOC, 5'd8,  4'd0,  1'b0, csba_pkg::ST_OK, 4'd0},
        '{csba_pkg::OP_ALLOC, 5'd8,  4'd0,  1'b0, csba_pkg::ST_OK, 4'd0},
        '{csba_pkg::OP_FREE,  5'd4,  4'd4,  1'b0, csba_pkg::ST_OK, 4'd0},
        '{csba_pkg::OP_ALLOC, 5'd5,  4'd0,  1'b0, csba_pkg::ST_OK, 4'd0},
        '{csba_pkg::OP_ALLOC, 5'd4,  4'd0,  1'b0, csba_pkg::ST_OK, 4'd0},
        '{csba_pkg::OP_FREE,  5'd16, 4'd0,  1'b0, csba_pkg::ST_OK, 4'd0},
        '{csba_pkg::OP_FREE,  5'd6,  4'd10, 1'b0, csba_pkg::ST_OK, 4'd0}
    };

    contiguous_slot_bitmap_allocator_top #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // first-fit allocate or range free on the shadow bitmap
    function automatic slot_reply_t serve_slot_request(
        input logic                        op,
        input logic [csba_pkg::CNT_W-1:0]  cnt,
        input logic [csba_pkg::SLOT_W-1:0] start);
        slot_reply_t reply;
        int          run;
        int          first;
        logic        fault;
        reply = '{csba_pkg::ST_OK, '0};
        if (op == csba_pkg::OP_ALLOC)
        begin
            if (cnt == 0)
                return reply;
            run = 0;
            for (int pos = 0; pos < NUM_SLOTS; pos++)
            begin
                if (!shadow_used[pos])
                begin
                    run++;
                    if (run >= cnt)
                    begin
                        first = pos + 1 - int'(cnt);
                        for (int k = first; k <= pos; k++)
                            shadow_used[k] = 1'b1;
                        reply.slot = first[csba_pkg::SLOT_W-1:0];
                        return reply;
                    end
                end
                else
                    run = 0;
            end
            reply.status = csba_pkg::ST_NOROOM;
        end
        else
        begin
            if (int'(start) + int'(cnt) > NUM_SLOTS)
            begin
                reply.status = csba_pkg::ST_PASTEND;
                return reply;
            end
            fault = 1'b0;
            for (int k = int'(start); k < int'(start) + int'(cnt); k++)
            begin
                if (shadow_used[k])
                    shadow_used[k] = 1'b0;
                else
                    fault = 1'b1;
            end
            if (fault)
                reply.status = csba_pkg::ST_NOTUSED;
        end
        return reply;
    endfunction

    // called just after a falling edge, returns just after a falling edge once the request is accepted
    task automatic drive_request(input logic op, input logic [csba_pkg::CNT_W-1:0] cnt,
                                 input logic [csba_pkg::SLOT_W-1:0] start,
                                 input logic fixed, input slot_reply_t typed_reply);
        int          gap;
        slot_reply_t predicted;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, start, cnt};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = serve_slot_request(op, cnt, start);
        awaited_replies.push_back(fixed ? typed_reply : predicted);
        if (op == csba_pkg::OP_ALLOC && cnt != 0 && predicted.status == csba_pkg::ST_OK)
            held_runs.push_back('{predicted.slot, cnt});
        sent_count++;
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        wait (awaited_replies.size() == 0);
        @(negedge clk);
    endtask

    // receiver: switches between free flow, light and heavy back-pressure
    int stall_mode = 0;
    int mode_left  = 0;
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 80);
        end
        mode_left--;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        slot_reply_t want;
        logic [csba_pkg::STAT_W-1:0] got_status;
        logic [csba_pkg::SLOT_W-1:0] got_slot;
        got_status = m_axis_tdata[1:0];
        got_slot   = m_axis_tdata[5:2];
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            status_tally[got_status]++;
            if (awaited_replies.size() == 0)
            begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("unexpected reply: status %0d slot %0d",
                             got_status, got_slot);
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (got_status !== want.status || got_slot !== want.slot)
                begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display({"reply mismatch: expected status %0d slot %0d,",
                                  " got status %0d slot %0d"},
                                 want.status, want.slot, got_status, got_slot);
                end
            end
        end
    end

    // watchdog on cycles where neither side moves a request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int                          pick;
        int                          idx;
        logic                        op;
        logic [csba_pkg::CNT_W-1:0]  cnt;
        logic [csba_pkg::SLOT_W-1:0] start;
        held_run_t                   run;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = csba_pkg::OP_ALLOC;
        s_axis_tdata  = '0;
        shadow_used   = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            drive_request(directed_rows[i].op, directed_rows[i].cnt, directed_rows[i].start,
                          directed_rows[i].fixed,
                          '{directed_rows[i].status, directed_rows[i].slot});
        held_runs.delete();
        hold_until_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 300 || n == 650)
                hold_until_drained();
            pick  = $urandom_range(0, 99);
            start = csba_pkg::SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
            if (pick < 45 || (pick < 80 && held_runs.size() == 0))
            begin
                op  = csba_pkg::OP_ALLOC;
                cnt = csba_pkg::CNT_W'(($urandom_range(0, 9) < 7) ?
                                       $urandom_range(1, 4) : $urandom_range(5, 16));
            end
            else if (pick < 80)
            begin
                idx   = $urandom_range(0, held_runs.size() - 1);
                run   = held_runs[idx];
                held_runs.delete(idx);
                op    = csba_pkg::OP_FREE;
                start = run.first;
                cnt   = run.len;
            end
            else if (pick < 88)
            begin
                // in-range free that may overlap held runs or free slots
                op  = csba_pkg::OP_FREE;
                cnt = csba_pkg::CNT_W'($urandom_range(1, NUM_SLOTS - int'(start)));
            end
            else
            begin
                op  = 1'($urandom_range(0, 1));
                cnt = csba_pkg::CNT_W'($urandom_range(0, 31));
            end
            drive_request(op, cnt, start, 1'b0, '{csba_pkg::ST_OK, '0});
        end

        s_axis_tvalid <= 1'b0;
        wait (awaited_replies.size() == 0);
        repeat (NUM_SLOTS + 4) @(posedge clk);
        if (awaited_replies.size() != 0)
            errors++;

        $display("%0d requests (%0d from the table) sent, %0d mismatches", sent_count,
                 $size(directed_rows), errors);
        $display("replies: ok %0d, no room %0d, not in use %0d, past end %0d",
                 status_tally[csba_pkg::ST_OK], status_tally[csba_pkg::ST_NOROOM],
                 status_tally[csba_pkg::ST_NOTUSED], status_tally[csba_pkg::ST_PASTEND]);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
